// ----- rtl/priority_task_dispatcher_top_assert.svh -----
// assertion macros used by the dispatcher checker
`ifndef PRIORITY_TASK_DISPATCHER_TOP_ASSERT_SVH
`define PRIORITY_TASK_DISPATCHER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define PTD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define PTD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ptd_pkg.sv -----
// types, constants and codes shared by the task dispatcher modules
`timescale 1ns / 1ps

package ptd_pkg;

    localparam int DEPTH       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int AW          = $clog2(DEPTH);
    localparam int CW          = $clog2(DEPTH + 1);
    localparam int RW          = $clog2(MAX_RESULTS + 1);
    localparam int ID_W        = 8;
    localparam int RT_W        = 8;
    localparam int PW          = 4;
    localparam int ENTRY_W     = ID_W + RT_W + PW;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 24;
    localparam int OUT_PAD     = OUT_DATA_W - ENTRY_W;

    localparam logic [PW-1:0] HIGHEST_RESET = 4'd10;

    typedef enum logic [1:0] {
        ACT_PUSH      = 2'd0,
        ACT_RUN_STACK = 2'd1,
        ACT_RUN_QUEUE = 2'd2,
        ACT_IGNORE    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_ACCEPT   = 2'd0,
        KIND_FULL     = 2'd1,
        KIND_DISPATCH = 2'd2,
        KIND_NOTHING  = 2'd3
    } t_kind;

    // id in the lowest bits, as on the streams
    typedef struct packed {
        logic [PW-1:0]   pri;
        logic [RT_W-1:0] rt;
        logic [ID_W-1:0] id;
    } t_entry;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_ACCEPT,
        EMIT_FULL,
        EMIT_LAST,
        EMIT_NOTHING
    } t_emit;

    typedef struct packed {
        logic  capture;
        logic  push_wr;
        t_emit emit;
        logic  run_init;
        logic  scan_rd;
        logic  scan_step;
        logic  comp_init;
        logic  comp_rd;
        logic  comp_wr;
        logic  comp_done;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic full;
        logic run_empty;
        logic hit;
        logic pend_valid;
        logic scan_last;
        logic comp_end;
    } t_dp_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_RUN_INIT,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_RUN_END,
        ST_COMP_RD,
        ST_COMP_WR
    } t_state;

endpackage

// ----- rtl/ptd_datapath.sv -----
// task store, scan counters, pending result and output register
`timescale 1ns / 1ps

module ptd_datapath
    import ptd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic [IN_DATA_W-1:0]  i_in_tdata,
    input  logic [1:0]            i_in_tuser,
    input  logic                  i_cfg_valid,
    input  logic [PW-1:0]         i_cfg_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [OUT_DATA_W-1:0] o_out_tdata,
    output logic [1:0]            o_out_tuser,
    output logic                  o_out_tlast
);

    t_entry            r_mem [DEPTH];
    t_entry            r_rd_data;
    t_entry            r_in_entry;
    t_entry            r_pend;
    t_entry            r_out_entry;
    logic [CW-1:0]     r_count;
    logic [PW-1:0]     r_highest;
    logic              r_pend_valid;
    logic              r_run_stack;
    logic [DEPTH-1:0]  r_gone;
    logic [AW-1:0]     r_slot;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_wr;
    logic [PW-1:0]     r_lvl;
    logic [RW-1:0]     r_n;
    logic              r_out_valid;
    t_kind             r_out_kind;
    logic              r_out_last;

    logic [CW-1:0]     scan_pos;
    logic [AW-1:0]     scan_addr;
    logic [AW-1:0]     rd_addr;
    logic              hit;
    logic              level_end;
    logic              comp_keep;
    logic              out_load;
    t_kind             n_out_kind;
    t_entry            n_out_entry;
    logic              n_out_last;

    // stack order walks from the newest slot down
    assign scan_pos  = r_run_stack ? (r_count - r_idx - CW'(1)) : r_idx;
    assign scan_addr = scan_pos[AW-1:0];
    assign rd_addr   = i_cmd.comp_rd ? r_idx[AW-1:0] : scan_addr;
    assign hit       = !r_gone[r_slot] && (r_rd_data.pri == r_lvl);
    assign level_end = (r_idx + CW'(1)) == r_count;
    assign comp_keep = !r_gone[r_idx[AW-1:0]];

    always_comb begin
        o_status            = '0;
        o_status.out_free   = !r_out_valid || i_out_ready;
        o_status.full       = r_count == CW'(DEPTH);
        o_status.run_empty  = (r_count == '0) || (r_highest == '0);
        o_status.hit        = hit;
        o_status.pend_valid = r_pend_valid;
        o_status.scan_last  = (level_end && (r_lvl == r_highest)) ||
                              (hit && ((r_n + RW'(1)) == RW'(MAX_RESULTS)));
        o_status.comp_end   = r_idx == r_count;
    end

    // a new hit pushes the previous one out, which therefore cannot be last
    always_comb begin
        out_load    = 1'b0;
        n_out_kind  = KIND_ACCEPT;
        n_out_entry = '0;
        n_out_last  = 1'b1;
        if (i_cmd.scan_step && hit && r_pend_valid) begin
            out_load    = 1'b1;
            n_out_kind  = KIND_DISPATCH;
            n_out_entry = r_pend;
            n_out_last  = 1'b0;
        end
        unique case (i_cmd.emit)
            EMIT_NONE: begin
            end
            EMIT_ACCEPT: begin
                out_load   = 1'b1;
                n_out_kind = KIND_ACCEPT;
            end
            EMIT_FULL: begin
                out_load   = 1'b1;
                n_out_kind = KIND_FULL;
            end
            EMIT_LAST: begin
                out_load    = 1'b1;
                n_out_kind  = KIND_DISPATCH;
                n_out_entry = r_pend;
            end
            EMIT_NOTHING: begin
                out_load   = 1'b1;
                n_out_kind = KIND_NOTHING;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_highest    <= HIGHEST_RESET;
            r_pend_valid <= 1'b0;
            r_run_stack  <= 1'b0;
            r_gone       <= '0;
            r_idx        <= '0;
            r_wr         <= '0;
            r_lvl        <= '0;
            r_n          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_highest <= i_cfg_data;
            end
            if (i_cmd.capture) begin
                r_run_stack <= t_action'(i_in_tuser) == ACT_RUN_STACK;
            end
            if (i_cmd.push_wr) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.run_init) begin
                r_gone       <= '0;
                r_lvl        <= PW'(1);
                r_idx        <= '0;
                r_n          <= '0;
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                if (hit) begin
                    r_gone[r_slot] <= 1'b1;
                    r_pend_valid   <= 1'b1;
                    r_n            <= r_n + RW'(1);
                end
                if (level_end) begin
                    r_idx <= '0;
                    r_lvl <= r_lvl + PW'(1);
                end else begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            if (i_cmd.comp_init) begin
                r_idx <= '0;
                r_wr  <= '0;
            end
            if (i_cmd.comp_wr) begin
                r_idx <= r_idx + CW'(1);
                if (comp_keep) begin
                    r_wr <= r_wr + CW'(1);
                end
            end
            if (i_cmd.comp_done) begin
                r_count <= r_wr;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_entry <= t_entry'(i_in_tdata[ENTRY_W-1:0]);
        end
        if (i_cmd.scan_step && hit) begin
            r_pend <= r_rd_data;
        end
        if (i_cmd.scan_rd) begin
            r_slot <= scan_addr;
        end
        if (out_load) begin
            r_out_kind  <= n_out_kind;
            r_out_entry <= n_out_entry;
            r_out_last  <= n_out_last;
        end
    end

    // slot memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_wr) begin
            r_mem[r_count[AW-1:0]] <= r_in_entry;
        end else if (i_cmd.comp_wr && comp_keep) begin
            r_mem[r_wr[AW-1:0]] <= r_rd_data;
        end
        if (i_cmd.scan_rd || i_cmd.comp_rd) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_tdata = {{OUT_PAD{1'b0}}, r_out_entry};
    assign o_out_tuser = r_out_kind;
    assign o_out_tlast = r_out_last;

endmodule

// ----- rtl/ptd_ctrl.sv -----
// sequencer for push, level scan and store compaction
`timescale 1ns / 1ps

module ptd_ctrl
    import ptd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_action    i_in_action,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_in_action) inside
                        ACT_PUSH:                     n_state = ST_PUSH;
                        ACT_RUN_STACK, ACT_RUN_QUEUE: n_state = ST_RUN_INIT;
                        default:                      n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PUSH: begin
                if (i_status.out_free) begin
                    o_cmd.emit    = i_status.full ? EMIT_FULL : EMIT_ACCEPT;
                    o_cmd.push_wr = !i_status.full;
                    n_state       = ST_IDLE;
                end
            end
            ST_RUN_INIT: begin
                o_cmd.run_init = 1'b1;
                n_state = i_status.run_empty ? ST_RUN_END : ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                // a hit with a result already held needs the output register
                if (!(i_status.hit && i_status.pend_valid) || i_status.out_free) begin
                    o_cmd.scan_step = 1'b1;
                    n_state = i_status.scan_last ? ST_RUN_END : ST_SCAN_RD;
                end
            end
            ST_RUN_END: begin
                if (i_status.out_free) begin
                    if (i_status.pend_valid) begin
                        o_cmd.emit      = EMIT_LAST;
                        o_cmd.comp_init = 1'b1;
                        n_state         = ST_COMP_RD;
                    end else begin
                        o_cmd.emit = EMIT_NOTHING;
                        n_state    = ST_IDLE;
                    end
                end
            end
            ST_COMP_RD: begin
                if (i_status.comp_end) begin
                    o_cmd.comp_done = 1'b1;
                    n_state         = ST_IDLE;
                end else begin
                    o_cmd.comp_rd = 1'b1;
                    n_state       = ST_COMP_WR;
                end
            end
            ST_COMP_WR: begin
                o_cmd.comp_wr = 1'b1;
                n_state       = ST_COMP_RD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/priority_task_dispatcher_top.sv -----
// Priority task dispatcher: stores up to DEPTH tasks and drains them level by level.
// Input stream (s_axis): one beat per command; tuser is the action (push, run in
// stack order, run in queue order, ignored code), tdata carries the pushed task.
// Output stream (m_axis): tuser is the result kind, tdata the dispatched task,
// tlast marks the final result of a command. A push gives one result; a run gives
// one beat per dispatched task, or a single "nothing" beat.
// Config channel: i_cfg_valid/o_cfg_ready/i_cfg_data sets the highest level served,
// always ready, to be written between commands.
// Timing: a command is taken in the idle state. A push gives its result through the
// output register once that register is free. A run scans the slots level by level,
// then compacts the store when something left it; the single slot memory read port
// gives each slot visit a read state and a check state. The next command is taken
// once the store is compacted, even while the last result still waits in the output
// register.
// Stall: when m_axis_tready is low the block holds the scan until the output
// register frees up; nothing is lost or repeated.
// Reset: synchronous, active low; the store empties and the level returns to 10.
`timescale 1ns / 1ps

module priority_task_dispatcher_top
    import ptd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // task_id, run_time, priority_req, zero pad
    input  logic [1:0]            s_axis_tuser,   // action
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [PW-1:0]         i_cfg_data,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // out_task_id, out_run_time, out_priority, zero pad
    output logic [1:0]            m_axis_tuser,   // kind
    output logic                  m_axis_tlast
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    ptd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_action (t_action'(s_axis_tuser)),
        .o_in_ready  (s_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ptd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_tdata  (s_axis_tdata),
        .i_in_tuser  (s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_tdata (m_axis_tdata),
        .o_out_tuser (m_axis_tuser),
        .o_out_tlast (m_axis_tlast)
    );

endmodule

// ----- rtl/ptd_checker.sv -----
// port-level checks of the dispatcher result stream
`timescale 1ns / 1ps
`include "priority_task_dispatcher_top_assert.svh"

module ptd_checker
    import ptd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [1:0]            m_axis_tuser,
    input logic                  m_axis_tlast
);

    t_entry                out_entry;
    logic                  out_status;
    logic                  out_stall;
    logic                  out_dispatch;
    logic [OUT_DATA_W+2:0] out_beat;

    assign out_entry    = t_entry'(m_axis_tdata[ENTRY_W-1:0]);
    assign out_status   = m_axis_tvalid && (t_kind'(m_axis_tuser) != KIND_DISPATCH);
    assign out_dispatch = m_axis_tvalid && (t_kind'(m_axis_tuser) == KIND_DISPATCH);
    assign out_stall    = m_axis_tvalid && !m_axis_tready;
    assign out_beat     = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

    // a stalled beat holds
    `PTD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, m_axis_tvalid && $stable(out_beat), "stalled result beat changed")

    // push and nothing results close their command
    `PTD_ASSERT_IMP(a_status_last, i_clk, i_rst_n, out_status, m_axis_tlast, "status result without tlast")

    `PTD_ASSERT_IMP(a_status_zero, i_clk, i_rst_n, out_status, m_axis_tdata == '0, "status result carries data")

    // level zero is never served
    `PTD_ASSERT_IMP(a_dispatch_level, i_clk, i_rst_n, out_dispatch, out_entry.pri != '0, "dispatched task of level zero")

endmodule

bind priority_task_dispatcher_top ptd_checker u_ptd_checker (.*);
